[hdl/ift_pkg.sv]
package ift_pkg;

    localparam int unsigned ETHERTYPE_IPV4  = 16'h0800;
    localparam int unsigned PROTO_NUM_TCP   = 6;
    localparam int unsigned PROTO_NUM_UDP   = 17;
    localparam int unsigned IHL_WORDS_LO    = 5;
    localparam int unsigned IHL_WORDS_HI    = 15;
    localparam int unsigned HDR_WORD_LEN    = 4;
    localparam int unsigned PORT_PAIR_LEN   = 4;

    localparam int unsigned ETH_HDR_BYTES   = 14;
    localparam int unsigned IPV4_BASE_LEN   = 20;
    localparam int unsigned ETYPE_HI_POS    = 12;
    localparam int unsigned ETYPE_LO_POS    = 13;
    localparam int unsigned IP_PROTO_POS    = 23;
    localparam int unsigned IP_SRC_FIRST    = 26;
    localparam int unsigned IP_SRC_LAST     = 29;
    localparam int unsigned IP_DST_FIRST    = 30;
    localparam int unsigned IP_DST_LAST     = 33;
    localparam int unsigned L4_OFS_BITS     = 7;

    typedef logic [L4_OFS_BITS-1:0] t_l4_ofs;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        sink_ready;
        logic [63:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic        record_valid;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  protocol;
        logic [15:0] frame_length;
        logic [63:0] timestamp;
        logic [63:0] frames_total;
        logic [63:0] records_dropped;
    } t_out_item;

    typedef struct packed {
        logic valid;
    } t_stage_ctl;

endpackage

[hdl/ift_if.sv]
interface ift_in_if;
    logic             valid;
    logic             ready;
    ift_pkg::t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ift_out_if;
    logic              valid;
    logic              ready;
    ift_pkg::t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[hdl/ift_in_stage.sv]
module ift_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ift_pkg::t_in_item i_item,
    output logic              o_ready,
    input  logic              i_take,
    output ift_pkg::t_stage_ctl o_ctl,
    output ift_pkg::t_in_item o_item
);

    logic              r_valid;
    ift_pkg::t_in_item r_item;
    logic              accept;

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_item      = r_item;

endmodule

[hdl/ift_core.sv]
module ift_core #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ift_pkg::t_stage_ctl i_ctl,
    input  ift_pkg::t_in_item  i_item,
    input  logic               i_out_free,
    output logic               o_take,
    output logic               o_load,
    output ift_pkg::t_out_item o_result
);

    localparam logic [LENGTH_BITS-1:0] OFS_MAX = {LENGTH_BITS{1'b1}};

    logic [LENGTH_BITS-1:0] r_offset, n_offset, c_offset;
    logic [15:0]            r_etype, n_etype, c_etype;
    logic [3:0]             r_ihl, n_ihl, c_ihl;
    logic [7:0]             r_proto, n_proto, c_proto;
    logic [31:0]            r_src, n_src, c_src;
    logic [31:0]            r_dst, n_dst, c_dst;
    logic [31:0]            r_ports, n_ports, c_ports;
    logic [63:0]            r_frames, n_frames;
    logic [63:0]            r_drops, n_drops;

    logic [LENGTH_BITS-1:0] pos;
    logic [7:0]             b;
    ift_pkg::t_l4_ofs       l4_old, l4_new;
    logic                   hdr_ok, ports_ok;
    logic [32:0]            total_w;

    assign pos    = r_offset;
    assign b      = i_item.data_byte;
    assign o_take = i_ctl.valid && (!i_item.last_byte || i_out_free);
    assign o_load = o_take && i_item.last_byte;

    assign l4_old = ift_pkg::t_l4_ofs'(ift_pkg::ETH_HDR_BYTES)
                  + ift_pkg::t_l4_ofs'(r_ihl) * ift_pkg::t_l4_ofs'(ift_pkg::HDR_WORD_LEN);
    assign l4_new = ift_pkg::t_l4_ofs'(ift_pkg::ETH_HDR_BYTES)
                  + ift_pkg::t_l4_ofs'(c_ihl) * ift_pkg::t_l4_ofs'(ift_pkg::HDR_WORD_LEN);

    // field capture for the byte at the current offset
    always_comb begin
        c_etype  = r_etype;
        c_ihl    = r_ihl;
        c_proto  = r_proto;
        c_src    = r_src;
        c_dst    = r_dst;
        c_ports  = r_ports;
        c_offset = (pos == OFS_MAX) ? pos : pos + LENGTH_BITS'(1);
        if (pos == LENGTH_BITS'(ift_pkg::ETYPE_HI_POS)
            || pos == LENGTH_BITS'(ift_pkg::ETYPE_LO_POS)) begin
            c_etype = {r_etype[7:0], b};
        end
        if (pos == LENGTH_BITS'(ift_pkg::ETH_HDR_BYTES)) begin
            c_ihl = b[3:0];
        end
        if (pos == LENGTH_BITS'(ift_pkg::IP_PROTO_POS)) begin
            c_proto = b;
        end
        if (pos >= LENGTH_BITS'(ift_pkg::IP_SRC_FIRST)
            && pos <= LENGTH_BITS'(ift_pkg::IP_SRC_LAST)) begin
            c_src = {r_src[23:0], b};
        end
        if (pos >= LENGTH_BITS'(ift_pkg::IP_DST_FIRST)
            && pos <= LENGTH_BITS'(ift_pkg::IP_DST_LAST)) begin
            c_dst = {r_dst[23:0], b};
        end
        // IHL is settled after byte 14, so the old value places the ports
        if (pos > LENGTH_BITS'(ift_pkg::ETH_HDR_BYTES)
            && pos >= LENGTH_BITS'(l4_old)
            && pos < LENGTH_BITS'(l4_old) + LENGTH_BITS'(ift_pkg::PORT_PAIR_LEN)) begin
            c_ports = {r_ports[23:0], b};
        end
    end

    assign total_w  = 33'(c_offset);
    assign hdr_ok   = c_offset >= LENGTH_BITS'(ift_pkg::ETH_HDR_BYTES + ift_pkg::IPV4_BASE_LEN)
                   && c_etype == 16'(ift_pkg::ETHERTYPE_IPV4)
                   && c_ihl >= 4'(ift_pkg::IHL_WORDS_LO)
                   && c_ihl <= 4'(ift_pkg::IHL_WORDS_HI);
    assign ports_ok = (c_proto == 8'(ift_pkg::PROTO_NUM_TCP)
                       || c_proto == 8'(ift_pkg::PROTO_NUM_UDP))
                   && c_offset >= LENGTH_BITS'(l4_new)
                                  + LENGTH_BITS'(ift_pkg::PORT_PAIR_LEN);

    always_comb begin
        n_offset = r_offset;
        n_etype  = r_etype;
        n_ihl    = r_ihl;
        n_proto  = r_proto;
        n_src    = r_src;
        n_dst    = r_dst;
        n_ports  = r_ports;
        n_frames = r_frames;
        n_drops  = r_drops;
        o_result = '0;
        if (o_take) begin
            if (i_item.last_byte) begin
                // clear per-frame state after the last byte
                n_offset = '0;
                n_etype  = '0;
                n_ihl    = '0;
                n_proto  = '0;
                n_src    = '0;
                n_dst    = '0;
                n_ports  = '0;
                n_frames = r_frames + 64'd1;
                if (hdr_ok && !i_item.sink_ready) begin
                    n_drops = r_drops + 64'd1;
                end
                if (hdr_ok && i_item.sink_ready) begin
                    o_result.record_valid   = 1'b1;
                    o_result.source_address = c_src;
                    o_result.dest_address   = c_dst;
                    if (ports_ok) begin
                        o_result.source_port = c_ports[31:16];
                        o_result.dest_port   = c_ports[15:0];
                    end
                    o_result.protocol     = c_proto;
                    o_result.frame_length = (total_w > 33'h0_FFFF) ? 16'hFFFF
                                                                   : total_w[15:0];
                    o_result.timestamp    = i_item.time_now;
                end
                o_result.frames_total    = n_frames;
                o_result.records_dropped = n_drops;
            end else begin
                n_offset = c_offset;
                n_etype  = c_etype;
                n_ihl    = c_ihl;
                n_proto  = c_proto;
                n_src    = c_src;
                n_dst    = c_dst;
                n_ports  = c_ports;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_etype  <= '0;
            r_ihl    <= '0;
            r_proto  <= '0;
            r_src    <= '0;
            r_dst    <= '0;
            r_ports  <= '0;
            r_frames <= '0;
            r_drops  <= '0;
        end else begin
            r_offset <= n_offset;
            r_etype  <= n_etype;
            r_ihl    <= n_ihl;
            r_proto  <= n_proto;
            r_src    <= n_src;
            r_dst    <= n_dst;
            r_ports  <= n_ports;
            r_frames <= n_frames;
            r_drops  <= n_drops;
        end
    end

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> (r_offset == '0 && r_etype == '0 && r_ihl == '0))
        else $error("per-frame state not cleared after last byte");

    a_mid_frame_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !i_item.last_byte)
        |=> (r_frames == $past(r_frames) && r_drops == $past(r_drops)))
        else $error("counters moved on a mid-frame byte");

    a_frame_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> (r_frames == $past(r_frames) + 64'd1))
        else $error("frame counter did not advance on last byte");

    a_record_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && o_result.record_valid) |=> (r_drops == $past(r_drops)))
        else $error("drop counted for an emitted record");

endmodule

[hdl/ift_out_stage.sv]
module ift_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ift_pkg::t_out_item i_result,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output ift_pkg::t_out_item o_item
);

    logic               r_valid;
    ift_pkg::t_out_item r_item;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

endmodule

[hdl/ipv4_flow_tuple_extractor.sv]
// A frame's result is registered: its last byte goes from the input register to the result register.
// Throughput: one byte per cycle unless stalled; input register, header-capture logic, result register.
// Bytes keep flowing while a result waits; only a last byte stalls on a full result register.
// Reset (synchronous, active low) clears frame state, both counters and both valid flags.
// Byte offset saturates at 2^LENGTH_BITS - 1; reported length saturates at 65535.
module ipv4_flow_tuple_extractor #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ift_in_if.sink    i_in,
    ift_out_if.source o_out
);

    ift_pkg::t_stage_ctl s1_ctl;
    ift_pkg::t_in_item   s1_item;
    ift_pkg::t_out_item  result;
    logic                take;
    logic                load;
    logic                out_free;

    ift_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .o_ready (i_in.ready),
        .i_take  (take),
        .o_ctl   (s1_ctl),
        .o_item  (s1_item)
    );

    ift_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s1_ctl),
        .i_item     (s1_item),
        .i_out_free (out_free),
        .o_take     (take),
        .o_load     (load),
        .o_result   (result)
    );

    ift_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_item   (o_out.data)
    );

endmodule
